// ===== src/selective_repeat_receive_window_unit_macros.svh =====
// assertion macros for the receive window checker
// used by srrw_checker; no other dependencies
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_MACROS_SVH

// same-cycle implication
`define SRRW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/srrw_pkg.sv =====
// shared types and constants of the selective repeat receive window
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

   localparam int WINDOW        = 32;
   localparam int SLOT_BITS     = $clog2(WINDOW);
   localparam int OCC_BITS      = SLOT_BITS + 1;
   localparam int SEGMENT_BYTES = 1000;
   localparam int RETRY_SPAN_US = 1000000;

   localparam logic [2:0] RK_REQUEST = 3'd0;
   localparam logic [2:0] RK_DELIVER = 3'd1;
   localparam logic [2:0] RK_ACCEPT  = 3'd2;
   localparam logic [2:0] RK_REJECT  = 3'd3;
   localparam logic [2:0] RK_DONE    = 3'd4;

   localparam logic REG_TOTAL_LENGTH = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_us;
      logic [31:0] arrived_offset;
      logic [9:0]  arrived_length;
      logic [15:0] payload_length;
      logic        header_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [4:0]  slot;
      logic [31:0] segment_offset;
      logic [9:0]  segment_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [9:0]  length;
      logic [15:0] retries;
      logic [31:0] last_request;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic       capture;
      logic       push;
      logic [2:0] push_kind;
      logic       flush;
      logic       deliver;
      logic       fill;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_head;
      logic       prod_ld;
      logic       req_wr;
      logic       set_rcvd;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic finished;
      logic occ_zero;
      logic head_rcvd;
      logic can_refill;
      logic scan_end;
      logic scan_rcvd;
      logic hdr_valid;
      logic match;
      logic skip_retry;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/srrw_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== src/srrw_ctrl.sv =====
// sequencer of the receive window: tick phases and arrival search
// depends on srrw_pkg
`timescale 1ns / 1ps
`default_nettype none

module srrw_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire srrw_pkg::sts_type sts,
   output srrw_pkg::cmd_type     cmd
);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_DISPATCH = 14'b00000000000010,
      ST_DLV_CHK  = 14'b00000000000100,
      ST_DLV_EMIT = 14'b00000000001000,
      ST_FILL     = 14'b00000000010000,
      ST_SC_CHK   = 14'b00000000100000,
      ST_SC_MUL   = 14'b00000001000000,
      ST_SC_DEC   = 14'b00000010000000,
      ST_FIN      = 14'b00000100000000,
      ST_AR_CHK   = 14'b00001000000000,
      ST_AR_WAIT  = 14'b00010000000000,
      ST_AR_CMP   = 14'b00100000000000,
      ST_FLUSH    = 14'b01000000000000,
      ST_SPARE    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.is_tick) begin
               state_in = sts.finished ? ST_FLUSH : ST_DLV_CHK;
            end else if (!sts.hdr_valid) begin
               cmd.push      = 1'b1;
               cmd.push_kind = srrw_pkg::RK_REJECT;
               state_in      = ST_FLUSH;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_AR_CHK;
            end
         end
         ST_DLV_CHK: begin
            cmd.rd_head = 1'b1;
            state_in    = (!sts.occ_zero && sts.head_rcvd) ? ST_DLV_EMIT : ST_FILL;
         end
         ST_DLV_EMIT: begin
            cmd.rd_head   = 1'b1;
            cmd.push      = 1'b1;
            cmd.push_kind = srrw_pkg::RK_DELIVER;
            cmd.deliver   = 1'b1;
            state_in      = ST_DLV_CHK;
         end
         ST_FILL: begin
            if (sts.can_refill) begin
               cmd.fill = 1'b1;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_SC_CHK;
            end
         end
         ST_SC_CHK: begin
            if (sts.scan_end) begin
               state_in = ST_FIN;
            end else if (sts.scan_rcvd) begin
               cmd.idx_inc = 1'b1;
            end else begin
               state_in = ST_SC_MUL;
            end
         end
         ST_SC_MUL: begin
            cmd.prod_ld = 1'b1;
            state_in    = ST_SC_DEC;
         end
         ST_SC_DEC: begin
            if (!sts.skip_retry) begin
               cmd.push      = 1'b1;
               cmd.push_kind = srrw_pkg::RK_REQUEST;
               cmd.req_wr    = 1'b1;
            end
            cmd.idx_inc = 1'b1;
            state_in    = ST_SC_CHK;
         end
         ST_FIN: begin
            if (sts.finished) begin
               cmd.push      = 1'b1;
               cmd.push_kind = srrw_pkg::RK_DONE;
            end
            state_in = ST_FLUSH;
         end
         ST_AR_CHK: begin
            if (sts.scan_end) begin
               cmd.push      = 1'b1;
               cmd.push_kind = srrw_pkg::RK_REJECT;
               state_in      = ST_FLUSH;
            end else begin
               state_in = ST_AR_WAIT;
            end
         end
         ST_AR_WAIT: begin
            state_in = ST_AR_CMP;
         end
         ST_AR_CMP: begin
            if (sts.match) begin
               cmd.push      = 1'b1;
               cmd.push_kind = srrw_pkg::RK_ACCEPT;
               cmd.set_rcvd  = 1'b1;
               state_in      = ST_FLUSH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_AR_CHK;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/srrw_dp.sv =====
// datapath of the receive window: counters, received bits, slot ram,
// retry timing multiply and the result holding stage; depends on srrw_pkg, srrw_ram
`timescale 1ns / 1ps
`default_nettype none

module srrw_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire srrw_pkg::req_type req_item,
   input  wire logic              cfg_we,
   input  wire logic [31:0]       cfg_wdata,
   output logic      [31:0]       total_length,
   input  wire srrw_pkg::cmd_type cmd,
   output srrw_pkg::sts_type      sts,
   output logic                   rsp_strobe,
   output srrw_pkg::rsp_type      rsp_item
);

   localparam int SB = srrw_pkg::SLOT_BITS;
   localparam int OB = srrw_pkg::OCC_BITS;

   logic [31:0]              total_ff;
   logic [SB-1:0]            head_ff;
   logic [OB-1:0]            occ_ff;
   logic [31:0]              next_off_ff;
   logic [31:0]              unassigned_ff;
   logic [31:0]              delivered_ff;
   logic [srrw_pkg::WINDOW-1:0] rcvd_ff;
   logic [OB-1:0]            idx_ff;
   srrw_pkg::req_type        item_ff;
   logic [37:0]              prod_ff;
   logic                     big_ff;
   logic                     pend_valid_ff;
   srrw_pkg::rsp_type        pend_ff;
   logic                     out_valid_ff;
   srrw_pkg::rsp_type        out_ff;

   logic [SB-1:0]       scan_slot;
   logic [SB-1:0]       fill_slot;
   logic [SB-1:0]       raddr;
   logic                we;
   logic [SB-1:0]       waddr;
   srrw_pkg::entry_type wentry;
   srrw_pkg::entry_type rentry;
   logic [9:0]          fill_len;
   logic [31:0]         waited;
   logic [15:0]         retries_inc;
   srrw_pkg::rsp_type   new_rsp;
   srrw_pkg::rsp_type   flush_rsp;

   assign scan_slot = head_ff + idx_ff[SB-1:0];
   assign fill_slot = head_ff + occ_ff[SB-1:0];
   assign raddr     = cmd.rd_head ? head_ff : scan_slot;
   assign fill_len  = (unassigned_ff < 32'(srrw_pkg::SEGMENT_BYTES)) ?
                      unassigned_ff[9:0] : 10'(srrw_pkg::SEGMENT_BYTES);
   assign waited    = item_ff.now_us - rentry.last_request;
   assign retries_inc = (rentry.retries != 16'hFFFF) ? rentry.retries + 16'd1
                                                     : rentry.retries;

   always_comb begin
      we     = cmd.fill | cmd.req_wr;
      waddr  = cmd.fill ? fill_slot : scan_slot;
      wentry = cmd.fill ? '{offset: next_off_ff, length: fill_len, retries: 16'd0,
                            last_request: item_ff.now_us}
                        : '{offset: rentry.offset, length: rentry.length,
                            retries: retries_inc, last_request: item_ff.now_us};
   end

   srrw_ram #(
      .WIDTH (srrw_pkg::ENTRY_BITS),
      .DEPTH (srrw_pkg::WINDOW)
   ) u_slot_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wentry),
      .raddr (raddr),
      .rdata (rentry)
   );

   always_comb begin
      sts.is_tick    = !item_ff.kind;
      sts.finished   = (delivered_ff == total_ff);
      sts.occ_zero   = (occ_ff == '0);
      sts.head_rcvd  = rcvd_ff[head_ff];
      sts.can_refill = (occ_ff < OB'(srrw_pkg::WINDOW)) && (unassigned_ff != '0);
      sts.scan_end   = (idx_ff == occ_ff);
      sts.scan_rcvd  = rcvd_ff[scan_slot];
      sts.hdr_valid  = item_ff.header_ok &&
                       ({6'd0, item_ff.arrived_length} == item_ff.payload_length);
      sts.match      = (rentry.offset == item_ff.arrived_offset) &&
                       (rentry.length == item_ff.arrived_length);
      sts.skip_retry = (rentry.retries != '0) && !big_ff &&
                       (prod_ff <= 38'(srrw_pkg::RETRY_SPAN_US));
   end

   always_comb begin
      new_rsp             = '0;
      new_rsp.result_kind = cmd.push_kind;
      case (cmd.push_kind)
         srrw_pkg::RK_DELIVER: begin
            new_rsp.slot           = head_ff;
            new_rsp.segment_offset = rentry.offset;
            new_rsp.segment_length = rentry.length;
         end
         srrw_pkg::RK_REQUEST: begin
            new_rsp.slot           = scan_slot;
            new_rsp.segment_offset = rentry.offset;
            new_rsp.segment_length = rentry.length;
         end
         srrw_pkg::RK_ACCEPT: begin
            new_rsp.slot           = scan_slot;
            new_rsp.segment_offset = item_ff.arrived_offset;
            new_rsp.segment_length = item_ff.arrived_length;
         end
         srrw_pkg::RK_REJECT: begin
            new_rsp.segment_offset = item_ff.arrived_offset;
            new_rsp.segment_length = item_ff.arrived_length;
         end
         default: begin
            new_rsp.slot = '0;
         end
      endcase
   end

   // held result with its last flag set
   always_comb begin
      flush_rsp      = pend_ff;
      flush_rsp.last = 1'b1;
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= 32'd1;
         head_ff       <= '0;
         occ_ff        <= '0;
         next_off_ff   <= '0;
         unassigned_ff <= 32'd1;
         delivered_ff  <= '0;
         rcvd_ff       <= '0;
         idx_ff        <= '0;
      end else if (cfg_we) begin
         total_ff      <= cfg_wdata;
         head_ff       <= '0;
         occ_ff        <= '0;
         next_off_ff   <= '0;
         unassigned_ff <= cfg_wdata;
         delivered_ff  <= '0;
         rcvd_ff       <= '0;
      end else begin
         if (cmd.deliver) begin
            delivered_ff     <= delivered_ff + {22'd0, rentry.length};
            rcvd_ff[head_ff] <= 1'b0;
            occ_ff           <= occ_ff - OB'(1);
            head_ff          <= head_ff + SB'(1);
         end
         if (cmd.fill) begin
            rcvd_ff[fill_slot] <= 1'b0;
            next_off_ff        <= next_off_ff + {22'd0, fill_len};
            unassigned_ff      <= unassigned_ff - {22'd0, fill_len};
            occ_ff             <= occ_ff + OB'(1);
         end
         if (cmd.set_rcvd) begin
            rcvd_ff[scan_slot] <= 1'b1;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + OB'(1);
         end
      end
   end

   // (waited + 1) * (retries + 1) <= span is the same test as waited < span / (retries + 1)
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      if (cmd.prod_ld) begin
         big_ff  <= (waited >= 32'(srrw_pkg::RETRY_SPAN_US));
         prod_ff <= ({1'b0, waited[19:0]} + 21'd1) * ({1'b0, rentry.retries} + 17'd1);
      end
   end

   // one result held back so that the last one of an item can be marked
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= 1'b0;
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) begin
               out_valid_ff <= 1'b1;
            end
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
            out_valid_ff  <= pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_ff <= new_rsp;
         out_ff  <= pend_ff;
      end else if (cmd.flush) begin
         out_ff <= flush_rsp;
      end
   end

   assign total_length = total_ff;
   assign rsp_strobe   = out_valid_ff;
   assign rsp_item     = out_ff;

endmodule

`default_nettype wire

// ===== src/selective_repeat_receive_window_unit.sv =====
// top level of the selective repeat receive window
// depends on srrw_pkg, srrw_ctrl, srrw_dp (with srrw_ram)
`timescale 1ns / 1ps
`default_nettype none

// the receiver cannot stall: each result item is on rsp_item for exactly one
// cycle, marked by rsp_strobe, and must be taken then. items go in one at a
// time: start is taken when busy is low. an arrival with a bad header is
// rejected without a search; otherwise it searches the window ram for the
// matching slot, one occupied slot after another. a tick delivers the received
// segments at the head, refills free slots, passes over received slots and takes
// each pending slot in the retry scan through a ram read, the retry multiply and
// a decision. a tick after completion goes straight to the final flush.
// the final result of an item is on the ports in the first cycle in which busy
// is low again. writing total_length restarts the transfer; write it only while
// idle.

module selective_repeat_receive_window_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   // item channel
   input  wire logic              start,
   output logic                   busy,
   input  wire srrw_pkg::req_type req_item,
   // result channel
   output logic                   rsp_strobe,
   output srrw_pkg::rsp_type      rsp_item,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   srrw_pkg::cmd_type cmd;
   srrw_pkg::sts_type sts;
   logic              cfg_we;
   logic [31:0]       total_length;

   // register write in the access phase
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == srrw_pkg::REG_TOTAL_LENGTH);
   assign prdata = (paddr[2] == srrw_pkg::REG_TOTAL_LENGTH) ? total_length : 32'd0;

   // sequencer
   srrw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // window state, slot ram and result stage
   srrw_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .cfg_we       (cfg_we),
      .cfg_wdata    (pwdata),
      .total_length (total_length),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

endmodule

`default_nettype wire

// ===== src/srrw_checker.sv =====
// port level checks of the receive window, bound to the top level
// depends on srrw_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_receive_window_unit_macros.svh"

module srrw_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire srrw_pkg::rsp_type rsp_item,
   input wire logic              rsp_strobe,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [2:0]        paddr,
   input wire logic [31:0]       pwdata,
   input wire logic [31:0]       prdata
);

   `SRRW_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "item taken but not busy")
   `SRRW_ASSERT_NOW(a_idle_last, clock, reset, rsp_strobe && !busy, rsp_item.last, "result while idle not last")
   `SRRW_ASSERT_NOW(a_done_last, clock, reset, rsp_strobe && (rsp_item.result_kind == srrw_pkg::RK_DONE), rsp_item.last, "completion not last")
   `SRRW_ASSERT_NEXT(a_reg_write, clock, reset, psel && penable && pwrite && (paddr == 3'd0), prdata == $past(pwdata), "register readback mismatch")

endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_item   (rsp_item),
   .rsp_strobe (rsp_strobe),
   .psel       (psel),
   .penable    (penable),
   .pwrite     (pwrite),
   .paddr      (paddr),
   .pwdata     (pwdata),
   .prdata     (prdata)
);

`default_nettype wire
